[design/pti_pkg.sv]
package pti_pkg;

  localparam int MAX_TEXT   = 4096;
  localparam int ALPHABET   = 26;
  localparam int NODE_COUNT = MAX_TEXT + 2;
  localparam int EDGE_DEPTH = NODE_COUNT * ALPHABET;
  localparam int TEXT_DEPTH = MAX_TEXT + 1;

  localparam int SYM_W   = 5;
  localparam int OUT_W   = 13;
  localparam int LEN_W   = 14;
  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int TEXT_AW = $clog2(TEXT_DEPTH);
  localparam int EDGE_AW = $clog2(EDGE_DEPTH);

  // The two roots: the empty palindrome and the imaginary one of length -1.
  localparam logic [NODE_W-1:0] ROOT_EMPTY = NODE_W'(0);
  localparam logic [NODE_W-1:0] ROOT_IMAG  = NODE_W'(1);

  typedef enum logic [7:0] {
    S_CLEAR     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_WALK_LEN  = 8'b0000_0100,
    S_WALK_TXT  = 8'b0000_1000,
    S_EDGE_CHK  = 8'b0001_0000,
    S_DONE      = 8'b0010_0000,
    S_SPARE_A   = 8'b0100_0000,
    S_SPARE_B   = 8'b1000_0000
  } state_e;

endpackage

[design/palindromic_tree_insert.sv]
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_stall_o    symbol_i
// out      output     out_valid_o / out_stall_i  suffix_start_o, suffix_length_o,
//                                                longest_so_far_o, node_total_o, full_flag_o
//
// One symbol is accepted in S_IDLE and then walks the suffix links: a node is skipped on
// length alone in S_WALK_LEN, or its mirrored symbol is read in S_WALK_LEN and S_WALK_TXT;
// then the edge is looked up in S_EDGE_CHK and the result is loaded in S_DONE. When a node
// is created, a second walk finds its suffix link; the suffix-link chains set the time taken.
// A refused symbol (store full) goes straight from S_IDLE to the result load in S_DONE.
// After reset the edge table is cleared one entry a cycle, all 106548 entries, during
// which in_stall_o stays high. The next symbol may enter while a result still waits
// on out_stall_i; only the final result load waits for the output register.
module palindromic_tree_insert
  import pti_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SYM_W-1:0]   symbol_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [OUT_W-1:0]   suffix_start_o,
  output logic [OUT_W-1:0]   suffix_length_o,
  output logic [OUT_W-1:0]   longest_so_far_o,
  output logic [OUT_W-1:0]   node_total_o,
  output logic               full_flag_o
);

  state_e state_q, state_d;

  logic [EDGE_AW-1:0]      clr_q, clr_d;
  logic [OUT_W-1:0]        pos_q, pos_d;
  logic [SYM_W-1:0]        sym_q, sym_d;
  logic [NODE_W-1:0]       v_q, v_d;
  logic [NODE_W-1:0]       cur_q, cur_d;
  logic [NODE_W-1:0]       link_q, link_d;
  logic signed [LEN_W-1:0] len_v_q, len_v_d;
  logic [OUT_W-1:0]        cur_len_q, cur_len_d;
  logic [OUT_W-1:0]        longest_q, longest_d;
  logic [NODE_W-1:0]       node_cnt_q, node_cnt_d;
  logic                    second_q, second_d;
  logic                    full_q, full_d;
  logic [EDGE_AW-1:0]      p_eaddr_q, p_eaddr_d;

  logic                    out_valid_q;
  logic [OUT_W-1:0]        o_start_q, o_len_q, o_longest_q, o_nodes_q;
  logic                    o_full_q;
  logic                    out_load;

  // Memories.
  logic [SYM_W-1:0]        text_mem [TEXT_DEPTH];
  logic signed [LEN_W-1:0] len_mem  [NODE_COUNT];
  logic [NODE_W-1:0]       link_mem [NODE_COUNT];
  logic [NODE_W-1:0]       edge_mem [EDGE_DEPTH];

  logic [SYM_W-1:0]        text_rd_q;
  logic signed [LEN_W-1:0] len_rd_q;
  logic [NODE_W-1:0]       link_rd_q;
  logic [NODE_W-1:0]       edge_rd_q;

  logic                    text_we;
  logic [TEXT_AW-1:0]      text_waddr, text_raddr;
  logic                    len_we, link_we, edge_we;
  logic [NODE_W-1:0]       node_waddr;
  logic signed [LEN_W-1:0] len_wdata;
  logic [EDGE_AW-1:0]      edge_waddr, edge_raddr;
  logic [NODE_W-1:0]       edge_wdata;

  logic [SYM_W-1:0]        sym_sat;
  logic signed [LEN_W-1:0] len_v;
  logic [NODE_W-1:0]       link_v;
  logic signed [LEN_W:0]   at_s;
  logic                    at_ok;
  logic signed [LEN_W-1:0] len_new;
  logic [NODE_W-1:0]       np;

  always_comb begin
    sym_sat = (symbol_i >= SYM_W'(ALPHABET)) ? SYM_W'(ALPHABET - 1) : symbol_i;
    len_v   = (v_q == ROOT_EMPTY) ? LEN_W'(0) :
              (v_q == ROOT_IMAG)  ? -LEN_W'(1) : len_rd_q;
    link_v  = (v_q == ROOT_EMPTY || v_q == ROOT_IMAG) ? ROOT_IMAG : link_rd_q;
    // Position of the symbol just before the palindrome of node v.
    at_s    = $signed({2'b00, pos_q}) - $signed({len_v[LEN_W-1], len_v})
              - $signed((LEN_W+1)'(1));
    at_ok   = (at_s > 0) && (at_s <= $signed({2'b00, pos_q}));
    len_new = len_v_q + LEN_W'(2);
    np      = (node_cnt_q == NODE_W'(NODE_COUNT - 1)) ? node_cnt_q : node_cnt_q + NODE_W'(1);
    edge_raddr = EDGE_AW'(v_q) * EDGE_AW'(ALPHABET) + EDGE_AW'(sym_q);
    text_raddr = at_s[TEXT_AW-1:0];
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pos_d      = pos_q;
    sym_d      = sym_q;
    v_d        = v_q;
    cur_d      = cur_q;
    link_d     = link_q;
    len_v_d    = len_v_q;
    cur_len_d  = cur_len_q;
    longest_d  = longest_q;
    node_cnt_d = node_cnt_q;
    second_d   = second_q;
    full_d     = full_q;
    p_eaddr_d  = p_eaddr_q;
    text_we    = 1'b0;
    text_waddr = pos_q + OUT_W'(1);
    len_we     = 1'b0;
    link_we    = 1'b0;
    edge_we    = 1'b0;
    node_waddr = node_cnt_q;
    len_wdata  = len_new;
    edge_waddr = clr_q;
    edge_wdata = node_cnt_q;

    case (state_q)
      S_CLEAR: begin
        edge_we    = 1'b1;
        edge_wdata = '0;
        clr_d      = clr_q + EDGE_AW'(1);
        if (clr_q == EDGE_AW'(EDGE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d = sym_sat;
          if (pos_q == OUT_W'(MAX_TEXT)) begin
            full_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            full_d   = 1'b0;
            pos_d    = pos_q + OUT_W'(1);
            text_we  = 1'b1;
            v_d      = cur_q;
            second_d = 1'b0;
            state_d  = S_WALK_LEN;
          end
        end
      end
      S_WALK_LEN: begin
        link_d  = link_v;
        len_v_d = len_v;
        if (at_ok) begin
          state_d = S_WALK_TXT;
        end else begin
          v_d = link_v;
        end
      end
      S_WALK_TXT: begin
        // On a match the edge read for (v, symbol) is issued at this edge.
        if (text_rd_q == sym_q) begin
          state_d = S_EDGE_CHK;
        end else begin
          v_d     = link_q;
          state_d = S_WALK_LEN;
        end
      end
      S_EDGE_CHK: begin
        if (!second_q) begin
          p_eaddr_d = edge_raddr;
          cur_len_d = len_new[OUT_W-1:0];
          if (edge_rd_q != '0) begin
            cur_d   = edge_rd_q;
            state_d = S_DONE;
          end else begin
            node_cnt_d = np;
            node_waddr = np;
            len_we     = 1'b1;
            if (len_new[OUT_W-1:0] > longest_q) begin
              longest_d = len_new[OUT_W-1:0];
            end
            second_d = 1'b1;
            v_d      = link_q;
            state_d  = S_WALK_LEN;
          end
        end else begin
          // Second walk found the suffix-link target: close the new node.
          link_we    = 1'b1;
          edge_we    = 1'b1;
          edge_waddr = p_eaddr_q;
          cur_d      = node_cnt_q;
          second_d   = 1'b0;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      v_q         <= ROOT_EMPTY;
      cur_q       <= ROOT_EMPTY;
      cur_len_q   <= '0;
      longest_q   <= '0;
      node_cnt_q  <= ROOT_IMAG;
      second_q    <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      pos_q      <= pos_d;
      v_q        <= v_d;
      cur_q      <= cur_d;
      cur_len_q  <= cur_len_d;
      longest_q  <= longest_d;
      node_cnt_q <= node_cnt_d;
      second_q   <= second_d;
      full_q     <= full_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    link_q    <= link_d;
    len_v_q   <= len_v_d;
    p_eaddr_q <= p_eaddr_d;
    if (out_load) begin
      o_start_q   <= pos_q - cur_len_q + OUT_W'(1);
      o_len_q     <= cur_len_q;
      o_longest_q <= longest_q;
      o_nodes_q   <= OUT_W'(node_cnt_q);
      o_full_q    <= full_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_waddr] <= sym_sat;
    end
    text_rd_q <= text_mem[text_raddr];
  end

  // Node memories are read at the node the walk moves to next.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[node_waddr] <= len_wdata;
    end
    if (link_we) begin
      link_mem[node_waddr] <= edge_rd_q;
    end
    len_rd_q  <= len_mem[v_d];
    link_rd_q <= link_mem[v_d];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rd_q <= edge_mem[edge_raddr];
  end

  assign out_valid_o      = out_valid_q;
  assign suffix_start_o   = o_start_q;
  assign suffix_length_o  = o_len_q;
  assign longest_so_far_o = o_longest_q;
  assign node_total_o     = o_nodes_q;
  assign full_flag_o      = o_full_q;

  a_cur_within_longest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len_q <= longest_q)
    else $error("current suffix longer than the longest palindrome");

  a_nodes_step_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(node_cnt_q) |-> node_cnt_q == $past(node_cnt_q) + NODE_W'(1))
    else $error("node count moved by more than one");

  a_suffix_within_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len_q <= pos_q && pos_q <= OUT_W'(MAX_TEXT))
    else $error("suffix length or position out of range");

endmodule

[dv/palindromic_tree_insert_tb.sv]
module palindromic_tree_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pti_pkg::*;

  localparam int RANDOM_ITEMS   = 627;
  localparam int DRAIN_CYCLES   = 32;
  // The edge table clear after reset alone walks all 106548 entries.
  localparam int WATCHDOG_LIMIT = 4 * EDGE_DEPTH;
  localparam int DIRECTED_ROWS  = 23;

  typedef struct packed {
    logic [OUT_W-1:0] suffix_start;
    logic [OUT_W-1:0] suffix_length;
    logic [OUT_W-1:0] longest_so_far;
    logic [OUT_W-1:0] node_total;
    logic             full_flag;
  } tree_out_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             typed;
    tree_out_t        want;
  } row_t;

  typedef enum int {
    MODE_PAIR,
    MODE_TRIPLE,
    MODE_RUN,
    MODE_MIRROR,
    MODE_NOISE
  } pattern_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [SYM_W-1:0] symbol_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [OUT_W-1:0] suffix_start_o;
  logic [OUT_W-1:0] suffix_length_o;
  logic [OUT_W-1:0] longest_so_far_o;
  logic [OUT_W-1:0] node_total_o;
  logic             full_flag_o;

  // Rows with typed set carry results worked out by hand; the rest use the predictor.
  row_t directed_rows [DIRECTED_ROWS] = '{
    '{5'd0,  1'b1, '{13'd1, 13'd1, 13'd1, 13'd2, 1'b0}},
    '{5'd0,  1'b1, '{13'd1, 13'd2, 13'd2, 13'd3, 1'b0}},
    '{5'd0,  1'b1, '{13'd1, 13'd3, 13'd3, 13'd4, 1'b0}},
    '{5'd31, 1'b1, '{13'd4, 13'd1, 13'd3, 13'd5, 1'b0}},
    '{5'd25, 1'b1, '{13'd4, 13'd2, 13'd3, 13'd6, 1'b0}},
    '{5'd26, 1'b1, '{13'd4, 13'd3, 13'd3, 13'd7, 1'b0}},
    '{5'd0,  1'b1, '{13'd3, 13'd5, 13'd5, 13'd8, 1'b0}},
    '{5'd1,  1'b0, '0},
    '{5'd0,  1'b0, '0},
    '{5'd1,  1'b0, '0},
    '{5'd0,  1'b0, '0},
    '{5'd1,  1'b0, '0},
    '{5'd16, 1'b0, '0},
    '{5'd15, 1'b0, '0},
    '{5'd30, 1'b0, '0},
    '{5'd16, 1'b0, '0},
    '{5'd1,  1'b0, '0},
    '{5'd0,  1'b0, '0},
    '{5'd0,  1'b0, '0},
    '{5'd2,  1'b0, '0},
    '{5'd2,  1'b0, '0},
    '{5'd0,  1'b0, '0},
    '{5'd24, 1'b0, '0}
  };

  // Predicted tree state.
  bit [SYM_W-1:0] sym_text [TEXT_DEPTH];
  int             node_len [NODE_COUNT];
  int             node_link [NODE_COUNT];
  int             child_node [EDGE_DEPTH];
  int             last_node;
  int             tail_node;
  int             text_len;
  int             best_len;

  tree_out_t awaited_outs [$];
  int        mismatches;
  int        stuck_cycles;
  int        quiet_in;
  int        quiet_out;

  pattern_e         pattern_mode;
  int               pattern_left;
  int               mirror_at;
  logic [SYM_W-1:0] letter_a;
  logic [SYM_W-1:0] letter_b;
  logic [SYM_W-1:0] letter_c;

  palindromic_tree_insert u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .symbol_i         (symbol_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .suffix_start_o   (suffix_start_o),
    .suffix_length_o  (suffix_length_o),
    .longest_so_far_o (longest_so_far_o),
    .node_total_o     (node_total_o),
    .full_flag_o      (full_flag_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int clamp_node(input int v);
    return (v >= 0 && v < NODE_COUNT) ? v : 1;
  endfunction

  // Follows suffix links from v until the symbol in front of the palindrome
  // matches the symbol at pos. The imaginary root always matches.
  function automatic int mirror_walk(input int v, input int pos);
    int node;
    int at;
    node = clamp_node(v);
    forever begin
      at = pos - node_len[node] - 1;
      if (at > 0 && at <= pos && sym_text[at] == sym_text[pos]) break;
      node = clamp_node(node_link[node]);
    end
    return node;
  endfunction

  function automatic tree_out_t append_symbol(input logic [SYM_W-1:0] raw);
    int        c;
    int        p;
    int        q;
    int        np;
    int        sfx;
    tree_out_t r;
    c = (raw >= ALPHABET) ? ALPHABET - 1 : int'(raw);
    r.full_flag = 1'b0;
    if (text_len >= MAX_TEXT) begin
      r.full_flag = 1'b1;
    end else begin
      text_len++;
      sym_text[text_len] = SYM_W'(c);
      p = mirror_walk(tail_node, text_len);
      if (child_node[p * ALPHABET + c] == 0) begin
        np = last_node + 1;
        if (np >= NODE_COUNT) np = NODE_COUNT - 1;
        last_node = np;
        node_len[np] = node_len[p] + 2;
        if (node_len[np] > best_len) best_len = node_len[np];
        q = mirror_walk(node_link[p], text_len);
        node_link[np] = child_node[q * ALPHABET + c];
        child_node[p * ALPHABET + c] = np;
      end
      tail_node = clamp_node(child_node[p * ALPHABET + c]);
    end
    sfx = node_len[clamp_node(tail_node)];
    if (sfx < 0) sfx = 0;
    r.suffix_start   = OUT_W'(text_len - sfx + 1);
    r.suffix_length  = OUT_W'(sfx);
    r.longest_so_far = OUT_W'(best_len);
    r.node_total     = OUT_W'(last_node);
    return r;
  endfunction

  // Mostly small alphabets, runs and mirrored stretches, so that long
  // palindromes and deep suffix-link chains show up; noise segments mix in
  // the whole 5-bit range, saturated symbols included.
  function automatic logic [SYM_W-1:0] next_symbol();
    logic [SYM_W-1:0] sym;
    if (pattern_left == 0) begin
      pattern_mode = pattern_e'($urandom_range(MODE_PAIR, MODE_NOISE));
      pattern_left = $urandom_range(6, 40);
      letter_a = SYM_W'($urandom_range(0, ALPHABET - 1));
      letter_b = SYM_W'($urandom_range(0, ALPHABET - 1));
      letter_c = SYM_W'($urandom_range(0, ALPHABET - 1));
      mirror_at = text_len - int'($urandom_range(0, 1));
    end
    pattern_left--;
    case (pattern_mode)
      MODE_PAIR: begin
        sym = $urandom_range(0, 1) ? letter_a : letter_b;
      end
      MODE_TRIPLE: begin
        case ($urandom_range(0, 2))
          0: sym = letter_a;
          1: sym = letter_b;
          default: sym = letter_c;
        endcase
      end
      MODE_RUN: begin
        sym = ($urandom_range(0, 7) == 0) ? letter_b : letter_a;
      end
      MODE_MIRROR: begin
        if (mirror_at >= 1) begin
          sym = sym_text[mirror_at];
          mirror_at--;
        end else begin
          sym = letter_a;
        end
      end
      default: begin
        sym = SYM_W'($urandom_range(0, 31));
      end
    endcase
    return sym;
  endfunction

  // Gap before the next transfer, with occasional stretches of no gaps at all.
  function automatic int draw_gap(inout int quiet);
    int gap;
    if (quiet > 0) begin
      quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 11) == 0) quiet = $urandom_range(10, 40);
    end
    return gap;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic typed,
                             input tree_out_t want);
    int        gap;
    tree_out_t predicted;
    gap = draw_gap(quiet_in);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = append_symbol(sym);
    awaited_outs.push_back(typed ? want : predicted);
  endtask

  initial begin
    node_len[1]  = -1;
    node_link[0] = 1;
    node_link[1] = 1;
    last_node    = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_symbol(directed_rows[i].sym, directed_rows[i].typed, directed_rows[i].want);
    end

    // Let the block drain completely before the random part.
    in_valid_i <= 1'b0;
    while (awaited_outs.size() != 0) @(posedge clk_i);

    for (int n = 0; n < RANDOM_ITEMS; n++) send_symbol(next_symbol(), 1'b0, '0);

    in_valid_i <= 1'b0;
    while (awaited_outs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_outs.size() == 0) begin
      $display("palindromic_tree_insert_tb: PASS");
    end else begin
      $display("palindromic_tree_insert_tb: FAIL");
    end
    $finish;
  end

  initial begin
    int        gap;
    tree_out_t got;
    tree_out_t want;
    wait (rst_ni);
    forever begin
      gap = draw_gap(quiet_out);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got = '{suffix_start_o, suffix_length_o, longest_so_far_o, node_total_o, full_flag_o};
      if (awaited_outs.size() == 0) begin
        report_mismatch("result with nothing expected, node_total",
                        int'(got.node_total), 0);
      end else begin
        want = awaited_outs.pop_front();
        if (got.suffix_start !== want.suffix_start)
          report_mismatch("suffix_start", int'(got.suffix_start), int'(want.suffix_start));
        if (got.suffix_length !== want.suffix_length)
          report_mismatch("suffix_length", int'(got.suffix_length),
                          int'(want.suffix_length));
        if (got.longest_so_far !== want.longest_so_far)
          report_mismatch("longest_so_far", int'(got.longest_so_far),
                          int'(want.longest_so_far));
        if (got.node_total !== want.node_total)
          report_mismatch("node_total", int'(got.node_total), int'(want.node_total));
        if (got.full_flag !== want.full_flag)
          report_mismatch("full_flag", int'(got.full_flag), int'(want.full_flag));
      end
    end
  end

  // Ends the run when neither channel completes a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("palindromic_tree_insert_tb: FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
